>>> rtl/core/ffsa_pkg.sv
package ffsa_pkg;

  localparam int MEM_WORDS    = 256;
  localparam int MAX_SEGMENTS = 16;

  localparam int PID_W  = 8;
  localparam int SIZE_W = 9;
  localparam int OUT_W  = 8;
  localparam int ADDR_W = $clog2(MEM_WORDS);
  localparam int IDX_W  = $clog2(MAX_SEGMENTS);
  localparam int CNT_W  = $clog2(MAX_SEGMENTS + 1);
  // Wide enough for base + size and for MEM_WORDS itself.
  localparam int CUR_W  = ((ADDR_W > SIZE_W) ? ADDR_W : SIZE_W) + 1;

  typedef enum logic {
    OP_ALLOC  = 1'b0,
    OP_LOOKUP = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_ALLOCATED  = 3'd0,
    ST_NO_SPACE   = 3'd1,
    ST_TABLE_FULL = 3'd2,
    ST_FOUND      = 3'd3,
    ST_NOT_FOUND  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_INSERT
  } state_t;

  typedef struct packed {
    op_t               op;
    logic [PID_W-1:0]  pid;
    logic [SIZE_W-1:0] req_size;
  } in_req_t;

  typedef struct packed {
    status_t          status;
    logic [OUT_W-1:0] seg_base;
    logic [OUT_W-1:0] seg_limit;
  } out_rsp_t;

  typedef struct packed {
    logic [PID_W-1:0]  pid;
    logic [ADDR_W-1:0] base;
    logic [SIZE_W-1:0] size;
  } entry_t;

  typedef struct packed {
    op_t               op;
    logic              at_end;
    logic [PID_W-1:0]  pid;
    logic [SIZE_W-1:0] req;
    logic [CUR_W-1:0]  cursor;
  } unit_ctrl_t;

  typedef struct packed {
    logic             hit;
    logic [CUR_W-1:0] cursor_nxt;
    logic [CUR_W-1:0] limit;
  } unit_res_t;

endpackage

>>> rtl/core/ffsa_table.sv
module ffsa_table (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [ffsa_pkg::IDX_W-1:0] rd_idx,
  output ffsa_pkg::entry_t       rd_entry,
  input  logic                   ins_en,
  input  logic [ffsa_pkg::IDX_W-1:0] ins_slot,
  input  ffsa_pkg::entry_t       ins_entry,
  output logic [ffsa_pkg::CNT_W-1:0] count
);
  import ffsa_pkg::*;

  entry_t            entry_r [MAX_SEGMENTS];
  logic [CNT_W-1:0]  count_r;

  assign rd_entry = entry_r[rd_idx];
  assign count    = count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (ins_en) begin
      count_r <= count_r + CNT_W'(1);
    end
  end

  // Insertion moves every entry above the slot up by one place, all in parallel.
  for (genvar k = 0; k < MAX_SEGMENTS; k++) begin : g_entry
    always_ff @(posedge clk) begin
      if (ins_en) begin
        if (IDX_W'(k) == ins_slot) begin
          entry_r[k] <= ins_entry;
        end else if (IDX_W'(k) > ins_slot) begin
          if (k > 0) begin
            entry_r[k] <= entry_r[(k > 0) ? k - 1 : 0];
          end
        end
      end
    end
  end

endmodule

>>> rtl/core/ffsa_scan_unit.sv
module ffsa_scan_unit (
  input  ffsa_pkg::unit_ctrl_t ctrl,
  input  ffsa_pkg::entry_t     entry,
  output ffsa_pkg::unit_res_t  res
);
  import ffsa_pkg::*;

  logic [CUR_W-1:0] base_w;
  logic [CUR_W-1:0] size_w;
  logic [CUR_W-1:0] bound;
  logic [CUR_W-1:0] gap;
  logic [CUR_W-1:0] lim_base;
  logic [CUR_W-1:0] lim_size;

  always_comb begin
    base_w = CUR_W'(entry.base);
    size_w = CUR_W'(entry.size);
    // Past the last entry the gap is closed by the end of memory.
    bound  = ctrl.at_end ? CUR_W'(MEM_WORDS) : base_w;
    gap    = (bound > ctrl.cursor) ? (bound - ctrl.cursor) : '0;

    if (ctrl.op == OP_LOOKUP) begin
      res.hit  = !ctrl.at_end && (entry.pid == ctrl.pid);
      lim_base = base_w;
      lim_size = size_w;
    end else begin
      res.hit  = (CUR_W'(ctrl.req) <= gap);
      lim_base = ctrl.cursor;
      lim_size = CUR_W'(ctrl.req);
    end

    res.cursor_nxt = base_w + size_w;
    res.limit      = lim_base + lim_size - CUR_W'(1);
  end

endmodule

>>> rtl/core/first_fit_segment_allocator.sv
// First-fit segment allocator over a word-addressed memory, keeping a table of
// segments sorted by base. An allocate takes the first gap from address 0 that
// holds the size, tail gap last; a lookup returns the lowest segment with the pid.
// A request is taken when start is high and busy is low. Its result appears for
// one cycle with out_valid and must be taken then: there is no way to stall it.
// Table full and zero-size allocates answer in the cycle after the transfer. Other
// requests walk the table one entry per cycle through a shared compare/add unit;
// an allocate then passes through an insert state that puts in the new entry with
// a parallel shift.
module first_fit_segment_allocator (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  ffsa_pkg::in_req_t in_req,
  output logic              out_valid,
  output ffsa_pkg::out_rsp_t out_rsp
);
  import ffsa_pkg::*;

  state_t            state_r, state_nxt;
  op_t               op_r, op_nxt;
  logic [PID_W-1:0]  pid_r, pid_nxt;
  logic [SIZE_W-1:0] req_r, req_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic [CUR_W-1:0]  cursor_r, cursor_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_rsp_t          out_rsp_r, out_rsp_nxt;

  entry_t            rd_entry;
  entry_t            ins_entry;
  logic              ins_en;
  logic [CNT_W-1:0]  count;
  logic              accept;
  logic              at_end;
  logic              full;
  unit_ctrl_t        uctrl;
  unit_res_t         ures;
  logic [CUR_W-1:0]  ent_base_w;

  assign accept     = start && !busy;
  assign busy       = (state_r != S_IDLE);
  assign at_end     = (idx_r == count);
  assign full       = (count >= CNT_W'(MAX_SEGMENTS));
  assign ent_base_w = CUR_W'(rd_entry.base);
  assign out_valid  = out_valid_r;
  assign out_rsp    = out_rsp_r;

  assign uctrl.op     = op_r;
  assign uctrl.at_end = at_end;
  assign uctrl.pid    = pid_r;
  assign uctrl.req    = req_r;
  assign uctrl.cursor = cursor_r;

  assign ins_entry.pid  = pid_r;
  assign ins_entry.base = cursor_r[ADDR_W-1:0];
  assign ins_entry.size = req_r;

  ffsa_table u_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_idx    (idx_r[IDX_W-1:0]),
    .rd_entry  (rd_entry),
    .ins_en    (ins_en),
    .ins_slot  (idx_r[IDX_W-1:0]),
    .ins_entry (ins_entry),
    .count     (count)
  );

  ffsa_scan_unit u_unit (
    .ctrl  (uctrl),
    .entry (rd_entry),
    .res   (ures)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_req.op == OP_LOOKUP) begin
            state_nxt = S_SCAN;
          end else if (!full && (in_req.req_size != '0)) begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (ures.hit) begin
          state_nxt = (op_r == OP_ALLOC) ? S_INSERT : S_IDLE;
        end else if (at_end) begin
          state_nxt = S_IDLE;
        end
      end
      S_INSERT: state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    op_nxt        = op_r;
    pid_nxt       = pid_r;
    req_nxt       = req_r;
    idx_nxt       = idx_r;
    cursor_nxt    = cursor_r;
    out_valid_nxt = 1'b0;
    out_rsp_nxt   = out_rsp_r;
    ins_en        = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt     = in_req.op;
          pid_nxt    = in_req.pid;
          req_nxt    = in_req.req_size;
          idx_nxt    = '0;
          cursor_nxt = '0;
          if (in_req.op == OP_ALLOC) begin
            if (full) begin
              out_valid_nxt = 1'b1;
              out_rsp_nxt   = '{status: ST_TABLE_FULL, seg_base: '0, seg_limit: '0};
            end else if (in_req.req_size == '0) begin
              out_valid_nxt = 1'b1;
              out_rsp_nxt   = '{status: ST_NO_SPACE, seg_base: '0, seg_limit: '0};
            end
          end
        end
      end
      S_SCAN: begin
        if (ures.hit) begin
          // On an allocate hit idx_r stays put and becomes the insert slot.
          if (op_r == OP_LOOKUP) begin
            out_valid_nxt = 1'b1;
            out_rsp_nxt   = '{status: ST_FOUND, seg_base: ent_base_w[OUT_W-1:0],
                              seg_limit: ures.limit[OUT_W-1:0]};
          end
        end else if (at_end) begin
          out_valid_nxt = 1'b1;
          out_rsp_nxt   = '{status: (op_r == OP_LOOKUP) ? ST_NOT_FOUND : ST_NO_SPACE,
                            seg_base: '0, seg_limit: '0};
        end else begin
          idx_nxt    = idx_r + CNT_W'(1);
          cursor_nxt = ures.cursor_nxt;
        end
      end
      S_INSERT: begin
        ins_en        = 1'b1;
        out_valid_nxt = 1'b1;
        out_rsp_nxt   = '{status: ST_ALLOCATED, seg_base: cursor_r[OUT_W-1:0],
                          seg_limit: ures.limit[OUT_W-1:0]};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    pid_r     <= pid_nxt;
    req_r     <= req_nxt;
    idx_r     <= idx_nxt;
    cursor_r  <= cursor_nxt;
    out_rsp_r <= out_rsp_nxt;
  end

`ifndef SYNTHESIS
  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    count <= CNT_W'(MAX_SEGMENTS))
    else $error("segment count exceeds table depth");

  a_alloc_grows_table: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_rsp.status == ST_ALLOCATED)) |-> (count == $past(count) + CNT_W'(1)))
    else $error("allocated result without a table insert");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && ((out_rsp.status == ST_NO_SPACE) || (out_rsp.status == ST_TABLE_FULL) ||
                   (out_rsp.status == ST_NOT_FOUND)))
    |-> ((out_rsp.seg_base == '0) && (out_rsp.seg_limit == '0)))
    else $error("failure result carries a nonzero address");

  a_busy_result: assert property (@(posedge clk) disable iff (!rst_n)
    (busy && !$past(busy) && $past(rst_n)) |-> !out_valid)
    else $error("result issued in the cycle a scan started");
`endif

endmodule
